@@ rtl/cdq_pkg.sv @@
// shared types and constants for the circular deque
package cdq_pkg;

   localparam int CMD_W  = 3;
   localparam int CNT_W  = 5;
   localparam int SUM_W  = 6;

   localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_QUERY      = 3'd4;

   typedef struct packed {
      logic load;
      logic exec;
      logic read;
   } dp_ctl_type;

endpackage

@@ rtl/cdq_ctrl.sv @@
// sequencer for the deque: capture, update, storage read, respond
module cdq_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output cdq_pkg::dp_ctl_type ctl
);
   import cdq_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_EXEC = 4'b0010,
      ST_READ = 4'b0100,
      ST_RESP = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: state_in = ST_READ;
         ST_READ: state_in = ST_RESP;
         ST_RESP: begin
            if (!rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);
   assign ctl.load  = (state_ff == ST_IDLE) && req_valid;
   assign ctl.exec  = (state_ff == ST_EXEC);
   assign ctl.read  = (state_ff == ST_READ);

endmodule

@@ rtl/cdq_dp.sv @@
// deque datapath: ring storage, head pointer, count and capacity
module cdq_dp #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  cdq_pkg::dp_ctl_type               ctl,
   input  logic                              csr_write_enable,
   input  logic [cdq_pkg::CNT_W-1:0]         csr_write_data,
   input  logic [cdq_pkg::CMD_W-1:0]         req_command,
   input  logic signed [DATA_WIDTH-1:0]      req_value,
   output logic                              rsp_ok,
   output logic signed [DATA_WIDTH-1:0]      rsp_front_value,
   output logic signed [DATA_WIDTH-1:0]      rsp_rear_value,
   output logic [cdq_pkg::CNT_W-1:0]         rsp_entries,
   output logic                              rsp_empty_res,
   output logic                              rsp_full_res
);
   import cdq_pkg::*;

   localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CapMax   = (DEPTH < 31) ? DEPTH : 31;
   localparam int CapReset = (DEPTH < 16) ? DEPTH : 16;
   localparam int POS_W    = (CapMax > 1) ? $clog2(CapMax) : 1;
   localparam logic [CNT_W-1:0] CAP_MAX = CNT_W'(CapMax);
   localparam logic [CNT_W-1:0] CAP_RST = CNT_W'(CapReset);

   logic [DATA_WIDTH-1:0] ring_ff [DEPTH];

   logic [CNT_W-1:0]      cap_ff, cap_in;
   logic [POS_W-1:0]      head_ff, head_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CMD_W-1:0]      cmd_ff;
   logic [DATA_WIDTH-1:0] value_ff;
   logic                  ok_ff, ok_in;
   logic [DATA_WIDTH-1:0] front_ff, rear_ff;

   logic                  wr_en;
   logic [POS_W-1:0]      wr_pos;
   logic [POS_W-1:0]      back_pos, next_head, prev_head, rear_pos;
   logic                  is_full, is_empty;

   function automatic logic [POS_W-1:0] ring_wrap(input logic [SUM_W-1:0] pos,
                                                  input logic [CNT_W-1:0] cap);
      logic [SUM_W-1:0] capx;
      capx = SUM_W'(cap);
      if (pos >= capx) return POS_W'(pos - capx);
      return POS_W'(pos);
   endfunction

   // clamp written capacity into 1..min(31, DEPTH)
   always_comb begin
      if (csr_write_data == '0) begin
         cap_in = CNT_W'(1);
      end else if (csr_write_data > CAP_MAX) begin
         cap_in = CAP_MAX;
      end else begin
         cap_in = csr_write_data;
      end
   end

   always_comb begin
      is_full   = (count_ff >= cap_ff);
      is_empty  = (count_ff == '0);
      back_pos  = ring_wrap(SUM_W'(head_ff) + SUM_W'(count_ff), cap_ff);
      next_head = ring_wrap(SUM_W'(head_ff) + SUM_W'(1), cap_ff);
      prev_head = (head_ff == '0) ? POS_W'(cap_ff - CNT_W'(1)) : head_ff - POS_W'(1);
      rear_pos  = ring_wrap(SUM_W'(head_ff) + SUM_W'(count_ff) - SUM_W'(1), cap_ff);

      head_in  = head_ff;
      count_in = count_ff;
      ok_in    = 1'b1;
      wr_en    = 1'b0;
      wr_pos   = back_pos;
      case (cmd_ff)
         CMD_PUSH_FRONT: begin
            if (is_full) begin
               ok_in = 1'b0;
            end else begin
               head_in  = prev_head;
               wr_pos   = prev_head;
               wr_en    = 1'b1;
               count_in = count_ff + CNT_W'(1);
            end
         end
         CMD_PUSH_BACK: begin
            if (is_full) begin
               ok_in = 1'b0;
            end else begin
               wr_en    = 1'b1;
               count_in = count_ff + CNT_W'(1);
            end
         end
         CMD_POP_FRONT: begin
            if (is_empty) begin
               ok_in = 1'b0;
            end else begin
               head_in  = next_head;
               count_in = count_ff - CNT_W'(1);
            end
         end
         CMD_POP_BACK: begin
            if (is_empty) begin
               ok_in = 1'b0;
            end else begin
               count_in = count_ff - CNT_W'(1);
            end
         end
         default: begin
            ok_in = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff   <= CAP_RST;
         head_ff  <= '0;
         count_ff <= '0;
      end else if (csr_write_enable) begin
         cap_ff   <= cap_in;
         head_ff  <= '0;
         count_ff <= '0;
      end else if (ctl.exec) begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff   <= req_command;
         value_ff <= req_value;
      end
      if (ctl.exec) begin
         ok_ff <= ok_in;
      end
   end

   // ring storage: one write port, front and rear read ports
   always_ff @(posedge clock) begin
      if (ctl.exec && wr_en) begin
         ring_ff[IDX_W'(wr_pos)] <= value_ff;
      end
      if (ctl.read) begin
         front_ff <= ring_ff[IDX_W'(head_ff)];
         rear_ff  <= ring_ff[IDX_W'(rear_pos)];
      end
   end

   assign rsp_ok          = ok_ff;
   assign rsp_front_value = is_empty ? '0 : front_ff;
   assign rsp_rear_value  = is_empty ? '0 : rear_ff;
   assign rsp_entries     = count_ff;
   assign rsp_empty_res   = is_empty;
   assign rsp_full_res    = (count_ff == cap_ff);

endmodule

@@ rtl/circular_deque.sv @@
// circular deque top level: controller and datapath
// the result beat follows the request beat through the update, registered storage read and
// respond steps of the controller; a new request beat is not taken until the previous
//   result beat has been accepted
// reset: synchronous, clears head and count, capacity to min(16, DEPTH); storage kept
module circular_deque #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [cdq_pkg::CNT_W-1:0]     csr_write_data,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [cdq_pkg::CMD_W-1:0]     req_command,
   input  logic signed [DATA_WIDTH-1:0]  req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_ok,
   output logic signed [DATA_WIDTH-1:0]  rsp_front_value,
   output logic signed [DATA_WIDTH-1:0]  rsp_rear_value,
   output logic [cdq_pkg::CNT_W-1:0]     rsp_entries,
   output logic                          rsp_empty_res,
   output logic                          rsp_full_res
);
   import cdq_pkg::*;

   dp_ctl_type ctl;

   cdq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .ctl       (ctl)
   );

   cdq_dp #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .ctl              (ctl),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_command      (req_command),
      .req_value        (req_value),
      .rsp_ok           (rsp_ok),
      .rsp_front_value  (rsp_front_value),
      .rsp_rear_value   (rsp_rear_value),
      .rsp_entries      (rsp_entries),
      .rsp_empty_res    (rsp_empty_res),
      .rsp_full_res     (rsp_full_res)
   );

endmodule

@@ bench/circular_deque_tb.sv @@
// self-checking testbench for the circular deque: directed and random beats against a predictor
module circular_deque_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import cdq_pkg::*;

   localparam int RING_DEPTH = 16;
   localparam int WORD_W     = 32;
   localparam int SETTLE     = 4;

   localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd5;
   localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_C = 3'd7;

   localparam logic [CNT_W-1:0] CAP_ZERO    = 5'd0;
   localparam logic [CNT_W-1:0] CAP_ONE     = 5'd1;
   localparam logic [CNT_W-1:0] CAP_TWO     = 5'd2;
   localparam logic [CNT_W-1:0] CAP_FULL    = 5'd16;
   localparam logic [CNT_W-1:0] CAP_OVER    = 5'd17;
   localparam logic [CNT_W-1:0] CAP_TOP     = 5'd31;

   localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
   localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7fff_ffff;

   typedef struct packed {
      logic                     ok;
      logic signed [WORD_W-1:0] front;
      logic signed [WORD_W-1:0] rear;
      logic [CNT_W-1:0]         entries;
      logic                     empty;
      logic                     full;
   } deque_view_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     csr_write_enable = 1'b0;
   logic [CNT_W-1:0]         csr_write_data = '0;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [CMD_W-1:0]         req_command = CMD_QUERY;
   logic signed [WORD_W-1:0] req_value = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic                     rsp_ok;
   logic signed [WORD_W-1:0] rsp_front_value;
   logic signed [WORD_W-1:0] rsp_rear_value;
   logic [CNT_W-1:0]         rsp_entries;
   logic                     rsp_empty_res;
   logic                     rsp_full_res;

   // predictor state
   logic signed [WORD_W-1:0] ring_words [RING_DEPTH];
   int                       head_pos = 0;
   int                       held = 0;
   logic [CNT_W-1:0]         cap_reg = CAP_FULL;

   deque_view_type           expected_views [$];
   int                       mismatches = 0;
   int                       send_idle_pct = 0;
   int                       stall_pct = 0;

   circular_deque #(
      .DEPTH      (RING_DEPTH),
      .DATA_WIDTH (WORD_W)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_ok           (rsp_ok),
      .rsp_front_value  (rsp_front_value),
      .rsp_rear_value   (rsp_rear_value),
      .rsp_entries      (rsp_entries),
      .rsp_empty_res    (rsp_empty_res),
      .rsp_full_res     (rsp_full_res)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   function automatic int usable_capacity();
      if (cap_reg < CAP_ONE) return 1;
      if (cap_reg > RING_DEPTH) return RING_DEPTH;
      return int'(cap_reg);
   endfunction

   function automatic int ring_slot(input int off, input int cap);
      int p;
      p = head_pos + off;
      while (p >= cap) p -= cap;
      return p;
   endfunction

   // applies one command to the predicted deque and returns the view after it
   function automatic deque_view_type apply_command(input logic [CMD_W-1:0] cmd,
                                                    input logic signed [WORD_W-1:0] word);
      deque_view_type v;
      int             cap;
      cap = usable_capacity();
      v = '0;
      v.ok = 1'b1;
      case (cmd)
         CMD_PUSH_FRONT: begin
            if (held >= cap) begin
               v.ok = 1'b0;
            end else begin
               head_pos = (head_pos == 0) ? cap - 1 : head_pos - 1;
               ring_words[head_pos] = word;
               held++;
            end
         end
         CMD_PUSH_BACK: begin
            if (held >= cap) begin
               v.ok = 1'b0;
            end else begin
               ring_words[ring_slot(held, cap)] = word;
               held++;
            end
         end
         CMD_POP_FRONT: begin
            if (held == 0) begin
               v.ok = 1'b0;
            end else begin
               head_pos = ring_slot(1, cap);
               held--;
            end
         end
         CMD_POP_BACK: begin
            if (held == 0) v.ok = 1'b0;
            else held--;
         end
         default: ;
      endcase
      if (held != 0) begin
         v.front = ring_words[head_pos];
         v.rear  = ring_words[ring_slot(held - 1, cap)];
      end
      v.entries = held[CNT_W-1:0];
      v.empty   = (held == 0);
      v.full    = (held == cap);
      return v;
   endfunction

   task automatic check_field(input string field, input logic [WORD_W-1:0] want,
                              input logic [WORD_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h actual %h", $realtime, field, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : rsp_checker
      deque_view_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_views.size() == 0) begin
            $display("%0t: unexpected result beat, expected none actual front %h entries %0d",
                     $realtime, rsp_front_value, rsp_entries);
            mismatches++;
         end else begin
            want = expected_views.pop_front();
            check_field("ok", WORD_W'(want.ok), WORD_W'(rsp_ok));
            check_field("front_value", want.front, rsp_front_value);
            check_field("rear_value", want.rear, rsp_rear_value);
            check_field("entries", WORD_W'(want.entries), WORD_W'(rsp_entries));
            check_field("empty_res", WORD_W'(want.empty), WORD_W'(rsp_empty_res));
            check_field("full_res", WORD_W'(want.full), WORD_W'(rsp_full_res));
         end
      end
   end

   // one request beat; valid stays high afterwards unless the next call idles
   task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic signed [WORD_W-1:0] word);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_value   <= word;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_views.push_back(apply_command(cmd, word));
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_views.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CNT_W-1:0] cap_value);
      drain_results();
      csr_write_enable <= 1'b1;
      csr_write_data   <= cap_value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cap_reg  = cap_value;
      head_pos = 0;
      held     = 0;
   endtask

   function automatic logic signed [WORD_W-1:0] pick_word();
      case ($urandom_range(15))
         0:       return WORD_MIN;
         1:       return WORD_MAX;
         2:       return '0;
         3:       return -1;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [CMD_W-1:0] pick_command(input int push_bias);
      int r;
      r = $urandom_range(99);
      if (r < 6) return CMD_QUERY;
      if (r < 9) begin
         case ($urandom_range(2))
            0:       return CMD_SPARE_A;
            1:       return CMD_SPARE_B;
            default: return CMD_SPARE_C;
         endcase
      end
      if ($urandom_range(99) < push_bias)
         return $urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
      return $urandom_range(1) ? CMD_POP_FRONT : CMD_POP_BACK;
   endfunction

   task automatic test_empty_after_reset();
      send_beat(CMD_QUERY, '0);
      send_beat(CMD_POP_FRONT, WORD_MAX);
      send_beat(CMD_POP_BACK, WORD_MIN);
      send_beat(CMD_SPARE_C, -1);
   endtask

   task automatic test_both_ends();
      send_beat(CMD_PUSH_FRONT, WORD_MIN);
      send_beat(CMD_PUSH_BACK, WORD_MAX);
      send_beat(CMD_PUSH_FRONT, -1);
      send_beat(CMD_PUSH_BACK, '0);
      send_beat(CMD_POP_FRONT, '0);
      send_beat(CMD_POP_BACK, '0);
      send_beat(CMD_QUERY, -1);
      send_beat(CMD_POP_BACK, '0);
      send_beat(CMD_POP_FRONT, '0);
   endtask

   task automatic test_unknown_commands();
      send_beat(CMD_PUSH_BACK, 32'sh1234_5678);
      send_beat(CMD_SPARE_A, WORD_MAX);
      send_beat(CMD_SPARE_B, WORD_MIN);
      send_beat(CMD_POP_FRONT, '0);
   endtask

   // zero acts as one, above the depth acts as the depth
   task automatic test_capacity_clamp();
      write_capacity(CAP_ZERO);
      send_beat(CMD_PUSH_BACK, 32'sh0bad_cafe);
      send_beat(CMD_PUSH_FRONT, WORD_MAX);
      send_beat(CMD_POP_FRONT, '0);
      send_beat(CMD_POP_FRONT, '0);
      write_capacity(CAP_TWO);
      send_beat(CMD_PUSH_FRONT, 32'sh5555_aaaa);
      send_beat(CMD_PUSH_BACK, 32'shaaaa_5555);
      send_beat(CMD_PUSH_BACK, -1);
      write_capacity(CAP_TOP);
      send_beat(CMD_QUERY, '0);
   endtask

   task automatic test_random_traffic();
      logic [CNT_W-1:0] caps [8];
      int               push_bias;
      int               tide_left;
      caps = '{CAP_FULL, CAP_ONE, CAP_TOP, 5'd3, CAP_OVER, CAP_ZERO, 5'd0, 5'd8};
      caps[6] = CNT_W'($urandom_range(0, 31));
      for (int phase = 0; phase < 8; phase++) begin
         write_capacity(caps[phase]);
         case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 87; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 87; end
            default: begin send_idle_pct = 31; stall_pct = 31; end
         endcase
         push_bias = 50;
         tide_left = 0;
         for (int n = 0; n < 72; n++) begin
            if (tide_left == 0) begin
               push_bias = $urandom_range(1) ? 75 : 25;
               tide_left = $urandom_range(4, 3 * usable_capacity() + 4);
            end
            tide_left--;
            send_beat(pick_command(push_bias), pick_word());
         end
      end
      send_idle_pct = 0;
      stall_pct = 0;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_empty_after_reset();
      test_both_ends();
      test_unknown_commands();
      test_capacity_clamp();
      test_random_traffic();
      drain_results();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && expected_views.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
